@@ rtl/core/cluster_chain_allocator_unit_assert.svh @@
// ---------------------------------------------------------------------------
// Assertion macros for the cluster chain allocator
// Shared macro forms for the concurrent checks bound to the top level.
// ---------------------------------------------------------------------------
`ifndef CLUSTER_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH
`define CLUSTER_CHAIN_ALLOCATOR_UNIT_ASSERT_SVH

// Check that is switched off while the reset is asserted.
`define CCA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Check that also holds while the reset is asserted.
`define CCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/core/cca_pkg.sv @@
// ---------------------------------------------------------------------------
// Cluster chain allocator package
// Table size, link codes, request kinds, status codes and shared types.
// ---------------------------------------------------------------------------
package cca_pkg;

    // Table geometry.
    localparam int TABLE_ENTRIES = 256;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
    localparam int CL_W          = 8;

    // Link values with a special meaning.
    localparam logic [CL_W-1:0] FREE     = 8'h00;
    localparam logic [CL_W-1:0] END_MARK = 8'hFF;

    // Last index that the free search looks at.
    localparam int SCAN_LAST_I = (TABLE_ENTRIES - 1 < 254) ? TABLE_ENTRIES - 1 : 254;
    localparam logic [CL_W-1:0] SCAN_LAST = CL_W'(SCAN_LAST_I);

    // A chain walk gives up after this many steps (counted from zero).
    localparam logic [7:0] WALK_LAST = 8'd255;

    // Reset value of the cluster shift register.
    localparam logic [3:0] SHIFT_RESET = 4'd9;

    // Request kinds.
    localparam logic [1:0] KIND_ALLOC   = 2'd0;
    localparam logic [1:0] KIND_RESIZE  = 2'd1;
    localparam logic [1:0] KIND_NEXT    = 2'd2;
    localparam logic [1:0] KIND_RELEASE = 2'd3;

    // Result status codes.
    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_FULL = 2'd1;
    localparam logic [1:0] ST_BAD  = 2'd2;

    // One access to the link memory: a read address and an optional write.
    typedef struct packed {
        logic [CL_W-1:0] rd_addr;
        logic            wr_en;
        logic [CL_W-1:0] wr_addr;
        logic [CL_W-1:0] wr_data;
    } mem_req_t;

    // One finished result.
    typedef struct packed {
        logic [CL_W-1:0] cluster;
        logic [1:0]      status;
    } result_t;

    // True for a cluster index that names a real table entry.
    function automatic logic link_ok(input logic [CL_W-1:0] c);
        return (c != FREE) && (c != END_MARK) && ({1'b0, c} < 9'(TABLE_ENTRIES));
    endfunction

endpackage

@@ rtl/core/cca_link_mem.sv @@
// ---------------------------------------------------------------------------
// Link table memory
// Synchronous link store with one read and one write port, a registered
// read, and a written flag per entry so that untouched entries read free.
// ---------------------------------------------------------------------------
module cca_link_mem
    import cca_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  mem_req_t        req,
    output logic [CL_W-1:0] rd_data
);

    logic [CL_W-1:0]          mem [TABLE_ENTRIES];
    logic [TABLE_ENTRIES-1:0] written_reg;
    logic [CL_W-1:0]          rdata_reg;
    logic                     rvalid_reg;
    logic                     rd_in;
    logic                     wr_in;
    logic                     fwd;
    logic [IDX_W-1:0]         rd_idx;
    logic [IDX_W-1:0]         wr_idx;

    // Addresses at or above the table size read as free and are never written.
    assign rd_in  = {1'b0, req.rd_addr} < 9'(TABLE_ENTRIES);
    assign wr_in  = req.wr_en && ({1'b0, req.wr_addr} < 9'(TABLE_ENTRIES));
    assign rd_idx = req.rd_addr[IDX_W-1:0];
    assign wr_idx = req.wr_addr[IDX_W-1:0];
    assign fwd    = wr_in && (req.wr_addr == req.rd_addr);

    // Data array with write-to-read forwarding on an address match.
    always_ff @(posedge clk)
    begin
        if (wr_in)
        begin
            mem[wr_idx] <= req.wr_data;
        end
        rdata_reg <= fwd ? req.wr_data : mem[rd_idx];
    end

    // Written flags, cleared together at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            rvalid_reg  <= 1'b0;
        end
        else
        begin
            if (wr_in)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
            rvalid_reg <= rd_in && (written_reg[rd_idx] || fwd);
        end
    end

    assign rd_data = rvalid_reg ? rdata_reg : FREE;

endmodule

@@ rtl/core/cca_ctrl.sv @@
// ---------------------------------------------------------------------------
// Cluster chain allocator sequencer
// Runs each request as a series of read-then-evaluate steps on the link
// memory: free search, chain walks, release, shrink and grow.
// ---------------------------------------------------------------------------
module cca_ctrl
    import cca_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    input  logic [1:0]      in_kind,
    input  logic [CL_W-1:0] in_head,
    input  logic [31:0]     in_old,
    input  logic [31:0]     in_new,
    input  logic [3:0]      shift,
    output logic            res_valid,
    input  logic            res_ready,
    output result_t         res,
    output mem_req_t        mem_req,
    input  logic [CL_W-1:0] rd_data
);

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_DECIDE  = 4'd1;
    localparam logic [3:0] S_NEXT_IS = 4'd2;
    localparam logic [3:0] S_NEXT_EV = 4'd3;
    localparam logic [3:0] S_REL_IS  = 4'd4;
    localparam logic [3:0] S_REL_EV  = 4'd5;
    localparam logic [3:0] S_SHR_IS  = 4'd6;
    localparam logic [3:0] S_SHR_EV  = 4'd7;
    localparam logic [3:0] S_WALK_IS = 4'd8;
    localparam logic [3:0] S_WALK_EV = 4'd9;
    localparam logic [3:0] S_SCAN_IS = 4'd10;
    localparam logic [3:0] S_SCAN_EV = 4'd11;
    localparam logic [3:0] S_GROW_WR = 4'd12;
    localparam logic [3:0] S_DONE    = 4'd13;

    logic [3:0]      state_reg,     state_next;
    logic [CL_W-1:0] head_reg,      head_next;
    logic [CL_W-1:0] cur_reg,       cur_next;
    logic [CL_W-1:0] tail_reg,      tail_next;
    logic [CL_W-1:0] scan_reg,      scan_next;
    logic [7:0]      steps_reg,     steps_next;
    logic [8:0]      pos_reg,       pos_next;
    logic [31:0]     old_cnt_reg,   old_cnt_next;
    logic [31:0]     new_cnt_reg,   new_cnt_next;
    logic [31:0]     left_reg,      left_next;
    logic            walk_grow_reg, walk_grow_next;
    logic            scan_grow_reg, scan_grow_next;
    logic [CL_W-1:0] cluster_reg,   cluster_next;
    logic [1:0]      status_reg,    status_next;

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Working registers of the current request.
    always_ff @(posedge clk)
    begin
        head_reg      <= head_next;
        cur_reg       <= cur_next;
        tail_reg      <= tail_next;
        scan_reg      <= scan_next;
        steps_reg     <= steps_next;
        pos_reg       <= pos_next;
        old_cnt_reg   <= old_cnt_next;
        new_cnt_reg   <= new_cnt_next;
        left_reg      <= left_next;
        walk_grow_reg <= walk_grow_next;
        scan_grow_reg <= scan_grow_next;
        cluster_reg   <= cluster_next;
        status_reg    <= status_next;
    end

    // Sequencer: each table step issues a read, then acts on the data.
    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cur_next       = cur_reg;
        tail_next      = tail_reg;
        scan_next      = scan_reg;
        steps_next     = steps_reg;
        pos_next       = pos_reg;
        old_cnt_next   = old_cnt_reg;
        new_cnt_next   = new_cnt_reg;
        left_next      = left_reg;
        walk_grow_next = walk_grow_reg;
        scan_grow_next = scan_grow_reg;
        cluster_next   = cluster_reg;
        status_next    = status_reg;
        mem_req        = '0;
        res_valid      = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    head_next    = in_head;
                    cur_next     = in_head;
                    steps_next   = 8'd0;
                    status_next  = ST_OK;
                    cluster_next = FREE;
                    if (in_kind == KIND_ALLOC)
                    begin
                        scan_next      = 8'd1;
                        scan_grow_next = 1'b0;
                        state_next     = S_SCAN_IS;
                    end
                    else if (!link_ok(in_head))
                    begin
                        status_next = ST_BAD;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        case (in_kind)
                            KIND_NEXT:    state_next = S_NEXT_IS;
                            KIND_RELEASE: state_next = S_REL_IS;
                            default:
                            begin
                                old_cnt_next = in_old >> shift;
                                new_cnt_next = in_new >> shift;
                                state_next   = S_DECIDE;
                            end
                        endcase
                    end
                end
            end

            // Resize: choose shrink, grow or just report the tail.
            S_DECIDE:
            begin
                pos_next = 9'd0;
                if (new_cnt_reg < old_cnt_reg)
                begin
                    state_next = S_SHR_IS;
                end
                else
                begin
                    left_next      = new_cnt_reg - old_cnt_reg;
                    walk_grow_next = new_cnt_reg > old_cnt_reg;
                    state_next     = S_WALK_IS;
                end
            end

            S_NEXT_IS:
            begin
                mem_req.rd_addr = head_reg;
                state_next      = S_NEXT_EV;
            end

            S_NEXT_EV:
            begin
                cluster_next = rd_data;
                state_next   = S_DONE;
            end

            // Release: free each entry while following its link.
            S_REL_IS:
            begin
                mem_req.rd_addr = cur_reg;
                state_next      = S_REL_EV;
            end

            S_REL_EV:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = cur_reg;
                mem_req.wr_data = FREE;
                if (!link_ok(rd_data) || (steps_reg == WALK_LAST))
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cur_next   = rd_data;
                    steps_next = steps_reg + 8'd1;
                    state_next = S_REL_IS;
                end
            end

            // Shrink: mark the end at the new count and free what follows.
            S_SHR_IS:
            begin
                mem_req.rd_addr = cur_reg;
                if ((32'(pos_reg) <= old_cnt_reg) && !pos_reg[8] && link_ok(cur_reg))
                begin
                    state_next = S_SHR_EV;
                end
                else
                begin
                    cur_next       = head_reg;
                    steps_next     = 8'd0;
                    walk_grow_next = 1'b0;
                    state_next     = S_WALK_IS;
                end
            end

            S_SHR_EV:
            begin
                mem_req.wr_addr = cur_reg;
                if (32'(pos_reg) == new_cnt_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = END_MARK;
                end
                else if (32'(pos_reg) > new_cnt_reg)
                begin
                    mem_req.wr_en   = 1'b1;
                    mem_req.wr_data = FREE;
                end
                cur_next   = rd_data;
                pos_next   = pos_reg + 9'd1;
                state_next = S_SHR_IS;
            end

            // Walk from the head to the last cluster of the chain.
            S_WALK_IS:
            begin
                mem_req.rd_addr = cur_reg;
                state_next      = S_WALK_EV;
            end

            S_WALK_EV:
            begin
                if (!link_ok(rd_data) || (steps_reg == WALK_LAST))
                begin
                    if (walk_grow_reg)
                    begin
                        tail_next      = link_ok(rd_data) ? rd_data : cur_reg;
                        scan_next      = 8'd1;
                        scan_grow_next = 1'b1;
                        state_next     = S_SCAN_IS;
                    end
                    else
                    begin
                        cluster_next = link_ok(rd_data) ? rd_data : cur_reg;
                        state_next   = S_DONE;
                    end
                end
                else
                begin
                    cur_next   = rd_data;
                    steps_next = steps_reg + 8'd1;
                    state_next = S_WALK_IS;
                end
            end

            // Free search, lowest index first.
            S_SCAN_IS:
            begin
                mem_req.rd_addr = scan_reg;
                state_next      = S_SCAN_EV;
            end

            S_SCAN_EV:
            begin
                if (rd_data == FREE)
                begin
                    mem_req.wr_en = 1'b1;
                    if (scan_grow_reg)
                    begin
                        mem_req.wr_addr = tail_reg;
                        mem_req.wr_data = scan_reg;
                        state_next      = S_GROW_WR;
                    end
                    else
                    begin
                        mem_req.wr_addr = scan_reg;
                        mem_req.wr_data = END_MARK;
                        cluster_next    = scan_reg;
                        state_next      = S_DONE;
                    end
                end
                else if (scan_reg == SCAN_LAST)
                begin
                    status_next = ST_FULL;
                    if (scan_grow_reg)
                    begin
                        cur_next       = head_reg;
                        steps_next     = 8'd0;
                        walk_grow_next = 1'b0;
                        state_next     = S_WALK_IS;
                    end
                    else
                    begin
                        cluster_next = FREE;
                        state_next   = S_DONE;
                    end
                end
                else
                begin
                    scan_next  = scan_reg + 8'd1;
                    state_next = S_SCAN_IS;
                end
            end

            // Grow: close the new cluster, then search for the next one or walk to the tail.
            S_GROW_WR:
            begin
                mem_req.wr_en   = 1'b1;
                mem_req.wr_addr = scan_reg;
                mem_req.wr_data = END_MARK;
                tail_next       = scan_reg;
                left_next       = left_reg - 32'd1;
                if ((left_reg == 32'd1) || (scan_reg == SCAN_LAST))
                begin
                    if (left_reg != 32'd1)
                    begin
                        status_next = ST_FULL;
                    end
                    cur_next       = head_reg;
                    steps_next     = 8'd0;
                    walk_grow_next = 1'b0;
                    state_next     = S_WALK_IS;
                end
                else
                begin
                    scan_next  = scan_reg + 8'd1;
                    state_next = S_SCAN_IS;
                end
            end

            S_DONE:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready    = (state_reg == S_IDLE);
    assign res.cluster = cluster_reg;
    assign res.status  = status_reg;

endmodule

@@ rtl/core/cluster_chain_allocator_unit.sv @@
// ---------------------------------------------------------------------------
// Cluster chain allocator
// Keeps a 256-entry table of 8-bit cluster links (0 free, 255 end of chain)
// and serves allocate, resize, next-link and release requests, one result
// word per request word. The table reads as all free after reset without a
// clearing pass. One request is worked at a time; every table step is a read
// of the registered link memory followed by an evaluate state. Next reads one
// link, allocate reads each entry searched, release each cluster freed,
// shrink each cluster walked plus the final walk, and grow each chain link to
// the tail and each entry searched, writes each cluster appended, and then
// reads each link of the final walk. The input side takes a new word as soon
// as the previous result has moved into the output register.
// ---------------------------------------------------------------------------
module cluster_chain_allocator_unit
    import cca_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,  // first_cluster[7:0], old_size[39:8], new_size[71:40]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // cluster[7:0]
    output logic [1:0]  m_axis_tuser,  // status[1:0]
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [3:0]  cfg_data
);

    logic [3:0]      shift_reg;
    logic            m_valid_reg;
    logic [CL_W-1:0] m_cluster_reg;
    logic [1:0]      m_status_reg;
    logic            res_valid;
    logic            res_ready;
    result_t         res;
    mem_req_t        mem_req;
    logic [CL_W-1:0] rd_data;

    // Cluster shift register, written whenever a configuration word arrives.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            shift_reg <= SHIFT_RESET;
        end
        else if (cfg_valid)
        begin
            shift_reg <= cfg_data;
        end
    end

    // Request sequencer.
    cca_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_kind   (s_axis_tuser),
        .in_head   (s_axis_tdata[7:0]),
        .in_old    (s_axis_tdata[39:8]),
        .in_new    (s_axis_tdata[71:40]),
        .shift     (shift_reg),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .mem_req   (mem_req),
        .rd_data   (rd_data)
    );

    // Link table.
    cca_link_mem u_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (mem_req),
        .rd_data (rd_data)
    );

    // Output register: holds one result word until the sink takes it.
    assign res_ready = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            m_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            m_cluster_reg <= res.cluster;
            m_status_reg  <= res.status;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_cluster_reg;
    assign m_axis_tuser  = m_status_reg;

endmodule

@@ rtl/core/cca_checker.sv @@
// ---------------------------------------------------------------------------
// Cluster chain allocator port checker
// Concurrent checks on the top-level ports, bound to every instance.
// ---------------------------------------------------------------------------
`include "cluster_chain_allocator_unit_assert.svh"

module cca_checker
    import cca_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [7:0]  m_axis_tdata,
    input logic [1:0]  m_axis_tuser
);

    // A request word is worked alone: the input closes right after it is taken.
    `CCA_ASSERT(a_one_at_a_time, clk, rst_n,
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready,
        "input accepted while a request is in progress")

    // A bad index result never carries a cluster.
    `CCA_ASSERT(a_bad_index_zero, clk, rst_n,
        m_axis_tvalid && (m_axis_tuser == ST_BAD) |-> (m_axis_tdata == FREE),
        "bad index result carries a cluster")

    // A stalled result word holds its value.
    `CCA_ASSERT(a_out_hold, clk, rst_n,
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser),
        "stalled result word changed")

    // No result word is offered while the reset is asserted.
    `CCA_ASSERT_ALWAYS(a_reset_quiet, clk, !rst_n |-> !m_axis_tvalid,
        "result offered during reset")

endmodule

bind cluster_chain_allocator_unit cca_checker u_cca_checker (.*);
